### rtl/core/cfpd_pkg.sv
// Package for the card frame parser and debouncer: field widths, command
// codes, register indexes, parser phase type and the check-byte function.
// No dependencies.
package cfpd_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned CARD_BYTES = 5;
    localparam int unsigned CARD_W     = CARD_BYTES * BYTE_W;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // input command codes
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_POLL = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_HEADER   = 3'd0,
        CFG_ROUTE_LOW      = 3'd1,
        CFG_ROUTE_HIGH     = 3'd2,
        CFG_DEBOUNCE_THR   = 3'd3,
        CFG_ABSENT_TIMEOUT = 3'd4
    } cfg_index_t;

    // register reset values
    localparam logic [BYTE_W-1:0] RST_FRAME_HEADER   = 8'd170;
    localparam logic [BYTE_W-1:0] RST_ROUTE_LOW      = 8'd48;
    localparam logic [BYTE_W-1:0] RST_ROUTE_HIGH     = 8'd51;
    localparam logic [BYTE_W-1:0] RST_DEBOUNCE_THR   = 8'd3;
    localparam logic [TIME_W-1:0] RST_ABSENT_TIMEOUT = 32'd1000;

    // frame parser phase
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_ROUTE  = 3'd1,
        PH_CARD0  = 3'd2,
        PH_CARD1  = 3'd3,
        PH_CARD2  = 3'd4,
        PH_CARD3  = 3'd5,
        PH_CARD4  = 3'd6,
        PH_CHECK  = 3'd7
    } parse_phase_t;

    // XOR of the five card bytes
    function automatic logic [BYTE_W-1:0] card_xor(input logic [CARD_W-1:0] card);
        logic [BYTE_W-1:0] x;
        x = '0;
        for (int i = 0; i < CARD_BYTES; i++) begin
            x = x ^ card[i*BYTE_W +: BYTE_W];
        end
        return x;
    endfunction

endpackage

### rtl/core/card_frame_parser_debouncer_top.sv
// Card frame parser and debouncer top level. Depends on cfpd_pkg.
// Path: an accepted transaction passes the input register, then the result
//   register, where a stalled result waits. Throughput: one transaction per
//   cycle unless m_ready stalls; one compare/update pass per item.
// Reset (aresetn low, synchronous): configuration returns to its defaults,
//   parser waits for a header, all card state is zero, both stages empty.
module card_frame_parser_debouncer_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic [cfpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cfpd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // input channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_command,
    input  logic [cfpd_pkg::BYTE_W-1:0]        s_rx_byte,
    input  logic [cfpd_pkg::TIME_W-1:0]        s_now_ms,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_frame_accepted,
    output logic                               m_new_card,
    output logic                               m_card_present,
    output logic [cfpd_pkg::BYTE_W-1:0]        m_card_route,
    output logic [cfpd_pkg::CARD_W-1:0]        m_card_code
);
    import cfpd_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] frame_header_reg;
    logic [BYTE_W-1:0] route_low_reg;
    logic [BYTE_W-1:0] route_high_reg;
    logic [BYTE_W-1:0] debounce_thr_reg;
    logic [TIME_W-1:0] absent_timeout_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_header_reg   <= RST_FRAME_HEADER;
            route_low_reg      <= RST_ROUTE_LOW;
            route_high_reg     <= RST_ROUTE_HIGH;
            debounce_thr_reg   <= RST_DEBOUNCE_THR;
            absent_timeout_reg <= RST_ABSENT_TIMEOUT;
        end else if (cfg_wr_en) begin
            // indexes past the last register are ignored
            unique case (cfg_index)
                CFG_FRAME_HEADER:   frame_header_reg   <= cfg_wdata[BYTE_W-1:0];
                CFG_ROUTE_LOW:      route_low_reg      <= cfg_wdata[BYTE_W-1:0];
                CFG_ROUTE_HIGH:     route_high_reg     <= cfg_wdata[BYTE_W-1:0];
                CFG_DEBOUNCE_THR:   debounce_thr_reg   <= cfg_wdata[BYTE_W-1:0];
                CFG_ABSENT_TIMEOUT: absent_timeout_reg <= cfg_wdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: input register -> result register
    // ------------------------------------------------------------------
    logic              in_valid_reg;
    logic              in_command_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic [TIME_W-1:0] in_now_reg;
    logic              out_valid_reg;
    logic              advance;   // item in input register commits this cycle

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_command_reg <= s_command;
            in_byte_reg    <= s_rx_byte;
            in_now_reg     <= s_now_ms;
        end
    end

    logic is_byte;
    logic is_poll;
    assign is_byte = advance && (in_command_reg == CMD_BYTE);
    assign is_poll = advance && (in_command_reg == CMD_POLL);

    // ------------------------------------------------------------------
    // Frame parser state
    // ------------------------------------------------------------------
    parse_phase_t      phase_reg, phase_next;
    logic [BYTE_W-1:0] frame_route_reg, frame_route_next;
    logic [CARD_W-1:0] frame_card_reg, frame_card_next;

    // debounce state
    logic [BYTE_W-1:0] pending_route_reg, pending_route_next;
    logic [CARD_W-1:0] pending_card_reg, pending_card_next;
    logic [BYTE_W-1:0] cand_route_reg, cand_route_next;
    logic [CARD_W-1:0] cand_card_reg, cand_card_next;
    logic [BYTE_W-1:0] match_count_reg, match_count_next;
    logic [BYTE_W-1:0] rep_route_reg, rep_route_next;
    logic [CARD_W-1:0] rep_card_reg, rep_card_next;
    logic [TIME_W-1:0] last_time_reg, last_time_next;

    logic route_ok;
    logic check_ok;
    logic frame_acc;
    logic report;

    assign route_ok = (in_byte_reg >= route_low_reg) && (in_byte_reg <= route_high_reg);
    assign check_ok = (in_byte_reg == card_xor(frame_card_reg));

    // parser next phase
    always_comb begin
        phase_next = phase_reg;
        if (is_byte) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (in_byte_reg == frame_header_reg) phase_next = PH_ROUTE;
                end
                PH_ROUTE: begin
                    // a header byte outside the route range in the route slot restarts the frame
                    if (route_ok)                             phase_next = PH_CARD0;
                    else if (in_byte_reg == frame_header_reg) phase_next = PH_ROUTE;
                    else                                      phase_next = PH_HEADER;
                end
                PH_CARD0: phase_next = PH_CARD1;
                PH_CARD1: phase_next = PH_CARD2;
                PH_CARD2: phase_next = PH_CARD3;
                PH_CARD3: phase_next = PH_CARD4;
                PH_CARD4: phase_next = PH_CHECK;
                PH_CHECK: phase_next = PH_HEADER;
                default:  phase_next = PH_HEADER;
            endcase
        end
    end

    // parser datapath and frame capture
    always_comb begin
        frame_route_next   = frame_route_reg;
        frame_card_next    = frame_card_reg;
        frame_acc          = 1'b0;
        if (is_byte) begin
            unique case (phase_reg)
                PH_HEADER: ;
                PH_ROUTE: begin
                    if (route_ok) begin
                        frame_route_next = in_byte_reg;
                        frame_card_next  = '0;
                    end
                end
                PH_CHECK: begin
                    if (check_ok) frame_acc = 1'b1;
                end
                default: begin
                    frame_card_next = {frame_card_reg[CARD_W-BYTE_W-1:0], in_byte_reg};
                end
            endcase
        end
    end

    // debounce / report / timeout
    logic              pend_match;
    logic [BYTE_W-1:0] count_upd;
    logic [TIME_W-1:0] elapsed;
    logic              timed_out;

    assign pend_match = (pending_route_reg == cand_route_reg) &&
                        (pending_card_reg == cand_card_reg);
    assign count_upd  = (match_count_reg < debounce_thr_reg) ?
                        match_count_reg + 8'd1 : match_count_reg;
    assign elapsed    = in_now_reg - last_time_reg;
    assign timed_out  = elapsed > absent_timeout_reg;

    always_comb begin
        pending_route_next = pending_route_reg;
        pending_card_next  = pending_card_reg;
        cand_route_next    = cand_route_reg;
        cand_card_next     = cand_card_reg;
        match_count_next   = match_count_reg;
        rep_route_next     = rep_route_reg;
        rep_card_next      = rep_card_reg;
        last_time_next     = last_time_reg;
        report             = 1'b0;

        if (frame_acc) begin
            // later frame overwrites the pending one; id zero leaves none pending
            pending_card_next  = frame_card_reg;
            pending_route_next = frame_route_reg - route_low_reg + 8'd1;
        end

        if (is_poll) begin
            if (pending_route_reg != '0) begin
                last_time_next = in_now_reg;
                if (pend_match) begin
                    match_count_next = count_upd;
                end else begin
                    cand_route_next  = pending_route_reg;
                    cand_card_next   = pending_card_reg;
                    match_count_next = 8'd1;
                end
                if ((match_count_next >= debounce_thr_reg) &&
                    ((rep_route_reg != cand_route_next) ||
                     (rep_card_reg != cand_card_next))) begin
                    rep_route_next = cand_route_next;
                    rep_card_next  = cand_card_next;
                    report         = 1'b1;
                end
                pending_route_next = '0;
            end else if ((cand_route_reg != '0) || (rep_route_reg != '0)) begin
                if (timed_out) begin
                    rep_route_next   = '0;
                    rep_card_next    = '0;
                    cand_route_next  = '0;
                    cand_card_next   = '0;
                    match_count_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_HEADER;
            frame_route_reg   <= '0;
            frame_card_reg    <= '0;
            pending_route_reg <= '0;
            pending_card_reg  <= '0;
            cand_route_reg    <= '0;
            cand_card_reg     <= '0;
            match_count_reg   <= '0;
            rep_route_reg     <= '0;
            rep_card_reg      <= '0;
            last_time_reg     <= '0;
        end else begin
            phase_reg         <= phase_next;
            frame_route_reg   <= frame_route_next;
            frame_card_reg    <= frame_card_next;
            pending_route_reg <= pending_route_next;
            pending_card_reg  <= pending_card_next;
            cand_route_reg    <= cand_route_next;
            cand_card_reg     <= cand_card_next;
            match_count_reg   <= match_count_next;
            rep_route_reg     <= rep_route_next;
            rep_card_reg      <= rep_card_next;
            last_time_reg     <= last_time_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic              out_acc_reg;
    logic              out_new_reg;
    logic [BYTE_W-1:0] out_route_reg;
    logic [CARD_W-1:0] out_card_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_acc_reg   <= frame_acc;
            out_new_reg   <= report;
            out_route_reg <= rep_route_next;
            out_card_reg  <= rep_card_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_frame_accepted = out_acc_reg;
    assign m_new_card       = out_new_reg;
    assign m_card_present   = (out_route_reg != '0);
    assign m_card_route     = out_route_reg;
    assign m_card_code      = out_card_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // an empty result stage never stalls the input side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("input stalled with empty result register");

    // a committed poll always consumes the pending card
    a_poll_consumes: assert property (@(posedge aclk) disable iff (!aresetn)
        is_poll |=> (pending_route_reg == '0))
        else $error("pending card survived a poll");

    // a reported card always carries a nonzero route
    a_report_present: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_new_card) |-> m_card_present)
        else $error("new card reported without a route");

    // a transaction never both accepts a frame and reports a new card
    a_excl_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_new_card) |-> !m_frame_accepted)
        else $error("frame accept and new card in one transaction");

endmodule

### sim/cfpd_tb_pkg.sv
// Scoreboard for the card frame parser/debouncer testbench: the status struct
// and a class that tracks parser and debounce state and checks each result.
// Depends on cfpd_pkg.
package cfpd_tb_pkg;
    import cfpd_pkg::*;

    typedef struct packed {
        logic              frame_accepted;
        logic              new_card;
        logic              card_present;
        logic [BYTE_W-1:0] card_route;
        logic [CARD_W-1:0] card_code;
    } card_status_t;

    class card_debounce_model;
        // register copies
        logic [BYTE_W-1:0] hdr;
        logic [BYTE_W-1:0] route_lo;
        logic [BYTE_W-1:0] route_hi;
        logic [BYTE_W-1:0] threshold;
        logic [TIME_W-1:0] timeout_ms;
        // parser and card state
        parse_phase_t      parse_ph;
        logic [BYTE_W-1:0] frm_route;
        logic [CARD_W-1:0] frm_card;
        logic [BYTE_W-1:0] pend_route;
        logic [CARD_W-1:0] pend_card;
        logic [BYTE_W-1:0] cand_route;
        logic [CARD_W-1:0] cand_card;
        logic [BYTE_W-1:0] match_cnt;
        logic [BYTE_W-1:0] rep_route;
        logic [CARD_W-1:0] rep_card;
        logic [TIME_W-1:0] last_seen_ms;
        card_status_t      expected_q[$];
        int                fail_count;

        function void reset_state();
            hdr          = RST_FRAME_HEADER;
            route_lo     = RST_ROUTE_LOW;
            route_hi     = RST_ROUTE_HIGH;
            threshold    = RST_DEBOUNCE_THR;
            timeout_ms   = RST_ABSENT_TIMEOUT;
            parse_ph     = PH_HEADER;
            frm_route    = '0;
            frm_card     = '0;
            pend_route   = '0;
            pend_card    = '0;
            cand_route   = '0;
            cand_card    = '0;
            match_cnt    = '0;
            rep_route    = '0;
            rep_card     = '0;
            last_seen_ms = '0;
            fail_count   = 0;
            expected_q.delete();
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_FRAME_HEADER:   hdr        = val[BYTE_W-1:0];
                CFG_ROUTE_LOW:      route_lo   = val[BYTE_W-1:0];
                CFG_ROUTE_HIGH:     route_hi   = val[BYTE_W-1:0];
                CFG_DEBOUNCE_THR:   threshold  = val[BYTE_W-1:0];
                CFG_ABSENT_TIMEOUT: timeout_ms = val[TIME_W-1:0];
                default: ;
            endcase
        endfunction

        // one accepted transaction -> one expected status
        function void note_item(logic cmd, logic [BYTE_W-1:0] b, logic [TIME_W-1:0] now);
            card_status_t      st;
            logic [BYTE_W-1:0] chk;
            logic [TIME_W-1:0] elapsed;
            st = '0;
            if (cmd == CMD_BYTE) begin
                case (parse_ph)
                    PH_HEADER: begin
                        if (b == hdr) parse_ph = PH_ROUTE;
                    end
                    PH_ROUTE: begin
                        if (b >= route_lo && b <= route_hi) begin
                            frm_route = b;
                            frm_card  = '0;
                            parse_ph  = PH_CARD0;
                        end else if (b == hdr) begin
                            parse_ph = PH_ROUTE;
                        end else begin
                            parse_ph = PH_HEADER;
                        end
                    end
                    PH_CHECK: begin
                        chk = frm_card[39:32] ^ frm_card[31:24] ^ frm_card[23:16]
                            ^ frm_card[15:8] ^ frm_card[7:0];
                        if (b == chk) begin
                            pend_card         = frm_card;
                            pend_route        = frm_route - route_lo + 8'd1;
                            st.frame_accepted = 1'b1;
                        end
                        parse_ph = PH_HEADER;
                    end
                    default: begin
                        frm_card = {frm_card[CARD_W-BYTE_W-1:0], b};
                        parse_ph = parse_phase_t'(parse_ph + 3'd1);
                    end
                endcase
            end else if (pend_route != 0) begin
                last_seen_ms = now;
                if (pend_route == cand_route && pend_card == cand_card) begin
                    if (match_cnt < threshold) match_cnt = match_cnt + 8'd1;
                end else begin
                    cand_route = pend_route;
                    cand_card  = pend_card;
                    match_cnt  = 8'd1;
                end
                if (match_cnt >= threshold &&
                    (rep_route != cand_route || rep_card != cand_card)) begin
                    rep_route   = cand_route;
                    rep_card    = cand_card;
                    st.new_card = 1'b1;
                end
                pend_route = '0;
            end else if (cand_route != 0 || rep_route != 0) begin
                elapsed = now - last_seen_ms;
                if (elapsed > timeout_ms) begin
                    rep_route  = '0;
                    rep_card   = '0;
                    cand_route = '0;
                    cand_card  = '0;
                    match_cnt  = '0;
                end
            end
            st.card_present = (rep_route != 0);
            st.card_route   = rep_route;
            st.card_code    = rep_card;
            expected_q.push_back(st);
        endfunction

        function void check_status(card_status_t got);
            card_status_t want;
            if (expected_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("result with no transaction outstanding: acc=%0b new=%0b",
                             got.frame_accepted, got.new_card);
                return;
            end
            want = expected_q.pop_front();
            if (got.frame_accepted !== want.frame_accepted ||
                got.new_card !== want.new_card ||
                got.card_present !== want.card_present ||
                got.card_route !== want.card_route ||
                got.card_code !== want.card_code) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("status mismatch: expected acc=%0b new=%0b present=%0b",
                             want.frame_accepted, want.new_card, want.card_present,
                             " route=%0h card=%010h", want.card_route, want.card_code);
                    $display("                 got      acc=%0b new=%0b present=%0b",
                             got.frame_accepted, got.new_card, got.card_present,
                             " route=%0h card=%010h", got.card_route, got.card_code);
                end
            end
        endfunction
    endclass

endpackage

### sim/tb_card_frame_parser_debouncer_top.sv
// Testbench for card_frame_parser_debouncer_top: drives bytes and polls with
// random gaps and result stalls, predicts every status and checks it in order.
// Depends on cfpd_pkg, cfpd_tb_pkg and the block's RTL.
module tb_card_frame_parser_debouncer_top;
    import cfpd_pkg::*;
    import cfpd_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_FRAME_HEADER;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic                  s_command = CMD_BYTE;
    logic [BYTE_W-1:0]     s_rx_byte = '0;
    logic [TIME_W-1:0]     s_now_ms  = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic                  m_frame_accepted;
    logic                  m_new_card;
    logic                  m_card_present;
    logic [BYTE_W-1:0]     m_card_route;
    logic [CARD_W-1:0]     m_card_code;

    card_debounce_model model;
    card_status_t       seen;
    logic [TIME_W-1:0]  clock_ms    = '0;   // running millisecond time for polls
    int                 items_sent  = 0;
    int                 idle_cycles = 0;
    int                 ready_hold  = 0;
    bit                 quiet_tail  = 1'b0; // no idling on either side when set

    card_frame_parser_debouncer_top uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_rx_byte        (s_rx_byte),
        .s_now_ms         (s_now_ms),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_accepted (m_frame_accepted),
        .m_new_card       (m_new_card),
        .m_card_present   (m_card_present),
        .m_card_route     (m_card_route),
        .m_card_code      (m_card_code)
    );

    always #2 aclk = ~aclk;

    // Result-side backpressure: random bursts of stall or ready, mostly ready;
    // m_ready changes only on a falling edge.
    always @(negedge aclk) begin
        if (quiet_tail) begin
            m_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
        end else if ($urandom_range(0, 2) == 0) begin
            m_ready    <= 1'b0;
            ready_hold = $urandom_range(0, 9);
        end else begin
            m_ready    <= 1'b1;
            ready_hold = $urandom_range(0, 29);
        end
    end

    // Monitor: note accepted transactions, check results, and watch for a hang.
    // Everything is sampled at the rising edge; stimulus moves on the falling one.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                model.note_item(s_command, s_rx_byte, s_now_ms);
            if (m_valid && m_ready) begin
                seen.frame_accepted = m_frame_accepted;
                seen.new_card       = m_new_card;
                seen.card_present   = m_card_present;
                seen.card_route     = m_card_route;
                seen.card_code      = m_card_code;
                model.check_status(seen);
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** card_frame_parser_debouncer_top: FAILED **");
            $finish;
        end
    end

    // One input transaction. Starts and ends on a falling edge; valid stays
    // high after acceptance so back-to-back items never toggle it.
    task automatic send_item(input logic cmd, input logic [BYTE_W-1:0] b,
                             input logic [TIME_W-1:0] now);
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_rx_byte <= b;
        s_now_ms  <= now;
        items_sent++;
        do @(posedge aclk); while (s_ready !== 1'b1);
        @(negedge aclk);
    endtask

    // now_ms is don't-care on a byte, so it carries noise
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        send_item(CMD_BYTE, b, $urandom);
    endtask

    // advance the millisecond clock (wrapping), then poll
    task automatic send_poll(input logic [TIME_W-1:0] advance);
        clock_ms = clock_ms + advance;
        send_item(CMD_POLL, $urandom_range(0, 255), clock_ms);
    endtask

    // header, route, five card bytes MSB first, XOR check (optionally corrupted)
    task automatic send_frame(input logic [BYTE_W-1:0] route_b,
                              input logic [CARD_W-1:0] card, input bit bad_check);
        logic [BYTE_W-1:0] chk;
        logic [BYTE_W-1:0] flip;
        chk  = card[39:32] ^ card[31:24] ^ card[23:16] ^ card[15:8] ^ card[7:0];
        flip = $urandom_range(1, 255);
        if (bad_check) chk = chk ^ flip;
        send_byte(model.hdr);
        send_byte(route_b);
        for (int i = CARD_BYTES - 1; i >= 0; i--) send_byte(card[i*BYTE_W +: BYTE_W]);
        send_byte(chk);
    endtask

    // Pause the sender until every result is back and checked, then idle.
    task automatic drain();
        s_valid <= 1'b0;
        while (model.expected_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_one(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        model.write_reg(idx, val);
        @(negedge aclk);
    endtask

    // Only called with the block idle (after drain).
    task automatic program_regs(input logic [CFG_DATA_W-1:0] hdr_v,
                                input logic [CFG_DATA_W-1:0] lo_v,
                                input logic [CFG_DATA_W-1:0] hi_v,
                                input logic [CFG_DATA_W-1:0] thr_v,
                                input logic [CFG_DATA_W-1:0] tmo_v);
        write_one(CFG_FRAME_HEADER, hdr_v);
        write_one(CFG_ROUTE_LOW, lo_v);
        write_one(CFG_ROUTE_HIGH, hi_v);
        write_one(CFG_DEBOUNCE_THR, thr_v);
        write_one(CFG_ABSENT_TIMEOUT, tmo_v);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Poll spacing: often short, some right at the absence timeout
    // (one below, equal, one above), some long, some arbitrary jumps.
    function automatic logic [TIME_W-1:0] pick_advance();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return $urandom_range(0, 20);
        if (r < 65) return model.timeout_ms + $urandom_range(0, 2) - 1;
        if (r < 85) return $urandom_range(0, 3000);
        return $urandom;
    endfunction

    // Random traffic under the current registers. Mostly well-formed frames
    // drawn from a small pool of routes and cards so the debounce count
    // climbs; the rest is broken frames, noise and polls.
    task automatic run_random(input int n_items);
        int                target;
        int                r;
        logic [BYTE_W-1:0] routes[2];
        logic [CARD_W-1:0] cards[3];
        logic [63:0]       wide;
        target = items_sent + n_items;
        if (model.route_lo <= model.route_hi) begin
            routes[0] = model.route_lo + $urandom_range(0, model.route_hi - model.route_lo);
            routes[1] = $urandom_range(0, 1) ? model.route_lo : model.route_hi;
        end else begin
            routes[0] = $urandom_range(0, 255);
            routes[1] = $urandom_range(0, 255);
        end
        wide     = {$urandom, $urandom};
        cards[0] = wide[CARD_W-1:0];
        wide     = {$urandom, $urandom};
        cards[1] = wide[CARD_W-1:0];
        cards[2] = $urandom_range(0, 1) ? '1 : '0;
        while (items_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                send_frame(routes[$urandom_range(0, 3) == 0],
                           cards[($urandom_range(0, 4) < 3) ? 0 : $urandom_range(1, 2)],
                           1'b0);
                if ($urandom_range(0, 9) < 7) send_poll(pick_advance());
            end else if (r < 62) begin
                send_poll(pick_advance());
            end else if (r < 70) begin
                send_frame(routes[0], cards[0], 1'b1);
            end else if (r < 78) begin
                // header, then a bad route: either a second header (resync)
                // or an arbitrary byte
                send_byte(model.hdr);
                if ($urandom_range(0, 1)) send_frame(routes[0], cards[0], 1'b0);
                else send_byte($urandom_range(0, 255));
            end else if (r < 86) begin
                repeat ($urandom_range(1, 4)) send_byte($urandom_range(0, 255));
            end else if (r < 91) begin
                // truncated frame followed by a poll (the parser holds its phase across polls)
                send_byte(model.hdr);
                send_byte(routes[0]);
                repeat ($urandom_range(0, 4)) send_byte($urandom_range(0, 255));
                send_poll(pick_advance());
            end else if (r < 97) begin
                wide = {$urandom, $urandom};
                send_frame($urandom_range(0, 255), wide[CARD_W-1:0], 1'b0);
            end else if (!quiet_tail) begin
                drain();
            end
        end
    endtask

    initial begin
        int lo_sel;
        int hi_sel;
        model = new;
        model.reset_state();

        // synchronous reset, released on a falling edge
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // --- directed, reset registers (header 0xAA, routes 0x30..0x33, threshold 3)
        send_poll(0);                           // nothing held: no timeout path
        send_byte(RST_FRAME_HEADER);            // next header lands in route slot
        send_frame(8'h33, '1, 1'b0);            // top route, all-ones card
        send_poll(10);                          // first match, below threshold
        send_byte(RST_FRAME_HEADER);
        send_byte(8'h00);                       // bad route, back to header hunt
        send_frame(8'h30, '0, 1'b1);            // bottom route, zero card, bad check
        send_byte(8'h2F);
        run_random(90);
        drain();

        // --- full route range with header 0xFF inside it; threshold 1, timeout 0
        program_regs(8'hFF, 8'h00, 8'hFF, 8'd1, 32'd0);
        send_frame(8'hFF, 40'h01_23_45_67_89, 1'b0); // route id wraps to 0: no card
        send_poll(5);
        send_frame(8'h00, 40'h01_23_45_67_89, 1'b0); // route id 1
        send_poll(1);                                // reported at once
        send_poll(0);                                // elapsed equals timeout: held
        send_poll(1);                                // elapsed past timeout: cleared
        run_random(80);
        drain();

        // --- empty route range, slowest debounce, longest timeout
        program_regs(8'h00, 8'd200, 8'd100, 8'd255, 32'hFFFF_FFFF);
        run_random(60);
        drain();

        // --- zero threshold: any pending card qualifies immediately
        lo_sel = $urandom_range(0, 250);
        program_regs($urandom_range(0, 255), lo_sel, lo_sel + $urandom_range(0, 5),
                     8'd0, $urandom_range(0, 50));
        run_random(80);
        drain();

        // --- assorted narrow ranges and short thresholds
        repeat (4) begin
            lo_sel = $urandom_range(0, 255);
            hi_sel = lo_sel + $urandom_range(0, 6);
            if (hi_sel > 255) hi_sel = 255;
            program_regs($urandom_range(0, 255), lo_sel, hi_sel,
                         $urandom_range(1, 4), $urandom_range(0, 3000));
            run_random(80);
            drain();
        end

        // --- back to reset values, full throughput, no idling
        program_regs(RST_FRAME_HEADER, RST_ROUTE_LOW, RST_ROUTE_HIGH,
                     RST_DEBOUNCE_THR, RST_ABSENT_TIMEOUT);
        quiet_tail = 1'b1;
        run_random(100);
        drain();

        if (model.fail_count == 0 && model.expected_q.size() == 0) begin
            $display("** card_frame_parser_debouncer_top: PASSED **");
        end else begin
            $display("** card_frame_parser_debouncer_top: FAILED **");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/cfpd_pkg.sv
rtl/core/card_frame_parser_debouncer_top.sv
sim/cfpd_tb_pkg.sv
sim/tb_card_frame_parser_debouncer_top.sv
